[hw/rtl/blra_pkg.sv]
// Package for the bezier leg reach animator: widths, field offsets, codes and state types.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package blra_pkg;

    // Curve resolution: NUM_POINTS+1 points per tick
    localparam int NUM_POINTS = 8;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int DELTA_W = 16;
    localparam int SPEED_W = 16;
    localparam int COORD_W = 32;
    localparam int IDX_W   = 7;
    localparam int PROG_W  = 17;             // Q1.16, 0..65536
    localparam int ONE_Q16 = 65536;

    // Progress step: (delta * speed) >> 8
    localparam int STEP_W = DELTA_W + SPEED_W - 8;
    localparam int PSUM_W = STEP_W + 2;

    // Remainder of progress / NUM_POINTS
    localparam int NP_W = $clog2(NUM_POINTS + 1);

    // Serial multiplier: signed multiplicand, unsigned 17-bit multiplier
    localparam int DIFF_W    = COORD_W + 1;
    localparam int MUL_A_W   = DIFF_W + 16 + 2;
    localparam int MUL_B_W   = PROG_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);
    localparam int RND_W     = MUL_P_W - 32;
    localparam int SUM_W     = RND_W + 1;

    // Serial divider
    localparam int DIV_CNT_W = $clog2(PROG_W + 1);

    // Stream packing, input side (tuser carries kind)
    localparam int S_DELTA_LSB  = 0;
    localparam int S_ACTIVE_BIT = S_DELTA_LSB + DELTA_W;
    localparam int S_TX_LSB     = S_ACTIVE_BIT + 1;
    localparam int S_TY_LSB     = S_TX_LSB + COORD_W;
    localparam int S_TZ_LSB     = S_TY_LSB + COORD_W;
    localparam int S_SX_LSB     = S_TZ_LSB + COORD_W;
    localparam int S_SY_LSB     = S_SX_LSB + COORD_W;
    localparam int S_SZ_LSB     = S_SY_LSB + COORD_W;
    localparam int S_USED_W     = S_SZ_LSB + COORD_W;
    localparam int S_TDATA_W    = ((S_USED_W + 7) / 8) * 8;

    // Stream packing, output side (tlast = last, tuser = hiding)
    localparam int M_PX_LSB  = 0;
    localparam int M_PY_LSB  = M_PX_LSB + COORD_W;
    localparam int M_PZ_LSB  = M_PY_LSB + COORD_W;
    localparam int M_IDX_LSB = M_PZ_LSB + COORD_W;
    localparam int M_USED_W  = M_IDX_LSB + IDX_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    // Register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_CTRL_HEIGHT = 1'b0;
    localparam logic [0:0] REG_ANIM_SPEED  = 1'b1;
    localparam logic signed [COORD_W-1:0] CTRL_HEIGHT_RST = 32'sd12800;
    localparam logic [SPEED_W-1:0]        ANIM_SPEED_RST  = 16'd256;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK       = 2'd0,
        KIND_SET_ACTIVE = 2'd1,
        KIND_SET_TARGET = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_STEP_WAIT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_PT_U,
        ST_PT_U_WAIT,
        ST_PT_T,
        ST_PT_T_WAIT,
        ST_PT_RND,
        ST_PT_OUT
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/blra_smul.sv]
// Serial shift-add multiplier: signed multiplicand times unsigned multiplier, one bit a cycle.
// Depends on blra_pkg for operand widths.
`default_nettype none

module blra_smul (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [blra_pkg::MUL_A_W-1:0]  a,
    input  wire logic        [blra_pkg::MUL_B_W-1:0]  b,
    output logic                                      busy,
    output logic signed      [blra_pkg::MUL_P_W-1:0]  product
);

    logic        [blra_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic signed [blra_pkg::MUL_P_W-1:0]   mcand_reg;
    logic        [blra_pkg::MUL_B_W-1:0]   mplier_reg;
    logic signed [blra_pkg::MUL_P_W-1:0]   acc_reg;
    logic signed [blra_pkg::MUL_P_W-1:0]   acc_next;

    // One partial product per cycle, LSB of the multiplier first
    assign acc_next = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= blra_pkg::MUL_CNT_W'(blra_pkg::MUL_B_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Operand shift registers and accumulator
    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= {{(blra_pkg::MUL_P_W - blra_pkg::MUL_A_W){a[blra_pkg::MUL_A_W-1]}}, a};
            mplier_reg <= b;
            acc_reg    <= '0;
        end else if (cnt_reg != '0) begin
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign busy    = (cnt_reg != '0);
    assign product = acc_reg;

endmodule

`default_nettype wire

[hw/rtl/blra_sdiv.sv]
// Serial restoring divider: progress divided by NUM_POINTS, one quotient bit a cycle.
// Depends on blra_pkg for widths and the divisor.
`default_nettype none

module blra_sdiv (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [blra_pkg::PROG_W-1:0]        dividend,
    output logic                                    busy,
    output logic      [blra_pkg::PROG_W-1:0]        quotient,
    output logic      [blra_pkg::NP_W-1:0]          remainder
);

    localparam logic [blra_pkg::NP_W:0] DIVISOR = (blra_pkg::NP_W + 1)'(blra_pkg::NUM_POINTS);

    logic [blra_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [blra_pkg::PROG_W-1:0]    shift_reg;
    logic [blra_pkg::NP_W-1:0]      rem_reg;
    logic [blra_pkg::NP_W:0]        trial;
    logic                           qbit;

    // Bring down the next dividend bit and try a subtract
    assign trial = {rem_reg, shift_reg[blra_pkg::PROG_W-1]};
    assign qbit  = (trial >= DIVISOR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= blra_pkg::DIV_CNT_W'(blra_pkg::PROG_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Dividend shifts out at the top while quotient bits shift in at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end else if (cnt_reg != '0) begin
            shift_reg <= {shift_reg[blra_pkg::PROG_W-2:0], qbit};
            rem_reg   <= qbit ? blra_pkg::NP_W'(trial - DIVISOR) : blra_pkg::NP_W'(trial);
        end
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = shift_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[hw/rtl/bezier_leg_reach_animator.sv]
// Top level of the bezier leg reach animator: register port, sequencer, serial arithmetic.
// Depends on blra_pkg, blra_smul and blra_sdiv.
//
// Usage:
//   Items enter on the s_ stream; s_tuser carries the kind (tick, set active, set target).
//   Set active and set target update state on acceptance and give no result. A tick moves
//   the progress ramp and, while the limb is active or still hiding, sends NUM_POINTS+1
//   curve points on the m_ stream, the final one flagged by m_tlast.
//   Sequence: a tick runs the progress step when a ramp runs, then progress / NUM_POINTS
//   on the serial divider when the limb is active or hiding, then each point in turn on
//   the bit-serial multipliers, two products per point (u*h on the z lane, then t*M on
//   all three lanes in parallel).
//   The block takes one item at a time; s_tready is high only between ticks.
//   Reset (aresetn low, synchronous) clears the ramps, progress and end point and loads
//   the register defaults (control_height 12800, animation_speed 256).
//   When the receiver stalls, the finished point waits in the output register and the
//   sequencer holds the next point until the register frees up; no point is dropped.
//   Write registers over the APB port only while idle; the block does not enforce it.
`default_nettype none

module bezier_leg_reach_animator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // tdata, LSB up: delta_time[16], active_flag[1], target_x, target_y, target_z,
    // start_x, start_y, start_z [32 each], zero pad
    input  wire logic [blra_pkg::S_TDATA_W-1:0]      s_tdata,
    // tuser: kind[2]
    input  wire logic [blra_pkg::KIND_W-1:0]         s_tuser,
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // tdata, LSB up: point_x, point_y, point_z [32 each], point_index[7], zero pad
    output logic [blra_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic                                     m_tlast,
    // tuser: hiding[1]
    output logic                                     m_tuser,
    // Register port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [blra_pkg::APB_AW-1:0]         paddr,
    input  wire logic [blra_pkg::APB_DW-1:0]         pwdata,
    output logic [blra_pkg::APB_DW-1:0]              prdata,
    output logic                                     pready
);

    localparam int CW = blra_pkg::COORD_W;
    localparam int AW = blra_pkg::MUL_A_W;
    localparam int PW = blra_pkg::MUL_P_W;
    localparam int DW = blra_pkg::DIFF_W;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    blra_pkg::state_t state_reg, state_next;

    logic signed [CW-1:0]               ctrl_height_reg;
    logic [blra_pkg::SPEED_W-1:0]       anim_speed_reg;

    logic leg_active_reg, leg_active_next;
    logic reaching_reg,   reaching_next;
    logic hiding_reg,     hiding_next;
    logic [blra_pkg::PROG_W-1:0]        progress_reg, progress_next;

    logic signed [CW-1:0] end_x_reg, end_y_reg, end_z_reg;
    logic signed [CW-1:0] start_x_reg, start_y_reg, start_z_reg;
    logic [blra_pkg::DELTA_W-1:0]       delta_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [AW-1:0] mz_reg;
    logic signed [blra_pkg::RND_W-1:0]  rnd_x_reg, rnd_y_reg, rnd_z_reg;

    logic [blra_pkg::PROG_W-1:0]        t_reg;
    logic [blra_pkg::NP_W-1:0]          tr_acc_reg;
    logic [blra_pkg::IDX_W-1:0]         idx_reg;

    logic                               m_tvalid_reg, m_tvalid_next;
    logic signed [CW-1:0]               out_x_reg, out_y_reg, out_z_reg;
    logic [blra_pkg::IDX_W-1:0]         out_idx_reg;
    logic                               out_last_reg;
    logic                               out_hiding_reg;

    // ---------------------------------------------------------------
    // Input unpacking
    // ---------------------------------------------------------------
    blra_pkg::kind_t kind;
    logic in_acc;
    logic active_in;

    assign kind      = blra_pkg::kind_t'(s_tuser);
    assign s_tready  = (state_reg == blra_pkg::ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign active_in = s_tdata[blra_pkg::S_ACTIVE_BIT];

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_height_reg <= blra_pkg::CTRL_HEIGHT_RST;
            anim_speed_reg  <= blra_pkg::ANIM_SPEED_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                blra_pkg::REG_CTRL_HEIGHT: ctrl_height_reg <= $signed(pwdata);
                blra_pkg::REG_ANIM_SPEED:  anim_speed_reg  <= pwdata[blra_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            blra_pkg::REG_CTRL_HEIGHT: prdata = ctrl_height_reg;
            blra_pkg::REG_ANIM_SPEED:  prdata = {{(blra_pkg::APB_DW - blra_pkg::SPEED_W){1'b0}},
                                                 anim_speed_reg};
            default:                   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Serial arithmetic units
    // ---------------------------------------------------------------
    logic mul_x_start, mul_y_start, mul_z_start;
    logic mul_x_busy,  mul_y_busy,  mul_z_busy;
    logic signed [AW-1:0] mul_x_a, mul_y_a, mul_z_a;
    logic [blra_pkg::MUL_B_W-1:0] mul_x_b, mul_z_b;
    logic signed [PW-1:0] mul_x_prod, mul_y_prod, mul_z_prod;
    logic [blra_pkg::PROG_W-1:0] u_val;

    logic div_start, div_busy;
    logic [blra_pkg::PROG_W-1:0] div_quot;
    logic [blra_pkg::NP_W-1:0]   div_rem;
    logic run_active;

    assign run_active = leg_active_reg || hiding_reg;
    assign u_val      = blra_pkg::PROG_W'(blra_pkg::ONE_Q16) - t_reg;

    // x lane also computes delta * speed for the progress step
    assign mul_x_start = (state_reg == blra_pkg::ST_STEP) || (state_reg == blra_pkg::ST_PT_T);
    assign mul_y_start = (state_reg == blra_pkg::ST_PT_T);
    assign mul_z_start = (state_reg == blra_pkg::ST_PT_U) || (state_reg == blra_pkg::ST_PT_T);

    assign mul_x_a = (state_reg == blra_pkg::ST_STEP)
                   ? $signed({{(AW - blra_pkg::SPEED_W){1'b0}}, anim_speed_reg})
                   : $signed({{(AW - DW - 16){dx_reg[DW-1]}}, dx_reg, 16'b0});
    assign mul_x_b = (state_reg == blra_pkg::ST_STEP) ? {1'b0, delta_reg} : t_reg;
    assign mul_y_a = $signed({{(AW - DW - 16){dy_reg[DW-1]}}, dy_reg, 16'b0});
    // z lane: u * h first, then t * M
    assign mul_z_a = (state_reg == blra_pkg::ST_PT_U)
                   ? $signed({{(AW - CW){ctrl_height_reg[CW-1]}}, ctrl_height_reg})
                   : mz_reg;
    assign mul_z_b = (state_reg == blra_pkg::ST_PT_U) ? u_val : t_reg;

    blra_smul u_mul_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_x_start),
        .a       (mul_x_a),
        .b       (mul_x_b),
        .busy    (mul_x_busy),
        .product (mul_x_prod)
    );

    blra_smul u_mul_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_y_start),
        .a       (mul_y_a),
        .b       (t_reg),
        .busy    (mul_y_busy),
        .product (mul_y_prod)
    );

    blra_smul u_mul_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_z_start),
        .a       (mul_z_a),
        .b       (mul_z_b),
        .busy    (mul_z_busy),
        .product (mul_z_prod)
    );

    assign div_start = (state_reg == blra_pkg::ST_DIV) && run_active;

    blra_sdiv u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (progress_reg),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // ---------------------------------------------------------------
    // Progress step
    // ---------------------------------------------------------------
    logic [blra_pkg::STEP_W-1:0]        step;
    logic signed [blra_pkg::PSUM_W-1:0] p_base, p_step, p_sum;
    logic p_over, p_under;

    assign step    = mul_x_prod[blra_pkg::DELTA_W + blra_pkg::SPEED_W - 1:8];
    assign p_base  = $signed({{(blra_pkg::PSUM_W - blra_pkg::PROG_W){1'b0}}, progress_reg});
    assign p_step  = $signed({{(blra_pkg::PSUM_W - blra_pkg::STEP_W){1'b0}}, step});
    assign p_sum   = reaching_reg ? p_base + p_step : p_base - p_step;
    assign p_over  = p_sum > $signed(blra_pkg::PSUM_W'(blra_pkg::ONE_Q16));
    assign p_under = p_sum[blra_pkg::PSUM_W-1];

    // ---------------------------------------------------------------
    // Point arithmetic
    // ---------------------------------------------------------------
    logic mul_all_busy;
    logic slot_free, out_load, idx_done;
    logic signed [PW-1:0] half_lsb;
    logic signed [PW-1:0] rs_x, rs_y, rs_z;
    logic [blra_pkg::NP_W:0] tr_sum;
    logic tr_carry;

    assign mul_all_busy = mul_x_busy || mul_y_busy || mul_z_busy;
    assign slot_free    = !m_tvalid_reg || m_tready;
    assign out_load     = (state_reg == blra_pkg::ST_PT_OUT) && slot_free;
    assign idx_done     = (idx_reg == blra_pkg::IDX_W'(blra_pkg::NUM_POINTS));

    // Round to nearest, ties up: (prod + 2^31) >>> 32
    assign half_lsb = $signed({{(PW - 32){1'b0}}, 1'b1, 31'b0});
    assign rs_x     = mul_x_prod + half_lsb;
    assign rs_y     = mul_y_prod + half_lsb;
    assign rs_z     = mul_z_prod + half_lsb;

    // t = floor(i*p/N) advanced as quotient plus a carry from the remainder
    assign tr_sum   = {1'b0, tr_acc_reg} + {1'b0, div_rem};
    assign tr_carry = (tr_sum >= (blra_pkg::NP_W + 1)'(blra_pkg::NUM_POINTS));

    function automatic logic signed [CW-1:0] sat_add(
        input logic signed [CW-1:0]              s,
        input logic signed [blra_pkg::RND_W-1:0] r
    );
        logic signed [blra_pkg::SUM_W-1:0] v;
        v = $signed({{(blra_pkg::SUM_W - CW){s[CW-1]}}, s}) + $signed({r[blra_pkg::RND_W-1], r});
        if (v[blra_pkg::SUM_W-1:CW-1] == '0 || v[blra_pkg::SUM_W-1:CW-1] == '1) begin
            return v[CW-1:0];
        end else if (v[blra_pkg::SUM_W-1]) begin
            return {1'b1, {(CW-1){1'b0}}};
        end else begin
            return {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    // ---------------------------------------------------------------
    // Sequencer: state register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= blra_pkg::ST_IDLE;
            leg_active_reg <= 1'b0;
            reaching_reg   <= 1'b0;
            hiding_reg     <= 1'b0;
            progress_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            leg_active_reg <= leg_active_next;
            reaching_reg   <= reaching_next;
            hiding_reg     <= hiding_next;
            progress_reg   <= progress_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Sequencer: next state and control updates
    always_comb begin
        state_next      = state_reg;
        leg_active_next = leg_active_reg;
        reaching_next   = reaching_reg;
        hiding_next     = hiding_reg;
        progress_next   = progress_reg;
        m_tvalid_next   = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

        unique case (state_reg)
            blra_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (kind)
                        blra_pkg::KIND_TICK: begin
                            state_next = (reaching_reg || hiding_reg) ? blra_pkg::ST_STEP
                                                                      : blra_pkg::ST_DIV;
                        end
                        blra_pkg::KIND_SET_ACTIVE: begin
                            leg_active_next = active_in;
                            if (active_in) begin
                                progress_next = '0;
                                reaching_next = 1'b1;
                            end else begin
                                progress_next = blra_pkg::PROG_W'(blra_pkg::ONE_Q16);
                                hiding_next   = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            blra_pkg::ST_STEP: state_next = blra_pkg::ST_STEP_WAIT;
            blra_pkg::ST_STEP_WAIT: begin
                if (!mul_x_busy) begin
                    if (p_over || p_under) begin
                        reaching_next = 1'b0;
                        hiding_next   = 1'b0;
                    end
                    if (p_over) begin
                        progress_next = blra_pkg::PROG_W'(blra_pkg::ONE_Q16);
                    end else if (p_under) begin
                        progress_next = '0;
                    end else begin
                        progress_next = p_sum[blra_pkg::PROG_W-1:0];
                    end
                    state_next = blra_pkg::ST_DIV;
                end
            end
            blra_pkg::ST_DIV: begin
                state_next = run_active ? blra_pkg::ST_DIV_WAIT : blra_pkg::ST_IDLE;
            end
            blra_pkg::ST_DIV_WAIT: begin
                if (!div_busy) begin
                    state_next = blra_pkg::ST_PT_U;
                end
            end
            blra_pkg::ST_PT_U: state_next = blra_pkg::ST_PT_U_WAIT;
            blra_pkg::ST_PT_U_WAIT: begin
                if (!mul_z_busy) begin
                    state_next = blra_pkg::ST_PT_T;
                end
            end
            blra_pkg::ST_PT_T: state_next = blra_pkg::ST_PT_T_WAIT;
            blra_pkg::ST_PT_T_WAIT: begin
                if (!mul_all_busy) begin
                    state_next = blra_pkg::ST_PT_RND;
                end
            end
            blra_pkg::ST_PT_RND: state_next = blra_pkg::ST_PT_OUT;
            blra_pkg::ST_PT_OUT: begin
                if (slot_free) begin
                    state_next = idx_done ? blra_pkg::ST_IDLE : blra_pkg::ST_PT_U;
                end
            end
            default: state_next = blra_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // End point (reset to origin)
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_x_reg <= '0;
            end_y_reg <= '0;
            end_z_reg <= '0;
        end else if (in_acc && kind == blra_pkg::KIND_SET_TARGET) begin
            end_x_reg <= $signed(s_tdata[blra_pkg::S_TX_LSB +: CW]);
            end_y_reg <= $signed(s_tdata[blra_pkg::S_TY_LSB +: CW]);
            end_z_reg <= $signed(s_tdata[blra_pkg::S_TZ_LSB +: CW]);
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        // Tick operands
        if (in_acc && kind == blra_pkg::KIND_TICK) begin
            delta_reg   <= s_tdata[blra_pkg::S_DELTA_LSB +: blra_pkg::DELTA_W];
            start_x_reg <= $signed(s_tdata[blra_pkg::S_SX_LSB +: CW]);
            start_y_reg <= $signed(s_tdata[blra_pkg::S_SY_LSB +: CW]);
            start_z_reg <= $signed(s_tdata[blra_pkg::S_SZ_LSB +: CW]);
        end

        // Per-tick setup: end minus start, point counters cleared
        if (state_reg == blra_pkg::ST_DIV) begin
            dx_reg     <= $signed({end_x_reg[CW-1], end_x_reg}) - $signed({start_x_reg[CW-1], start_x_reg});
            dy_reg     <= $signed({end_y_reg[CW-1], end_y_reg}) - $signed({start_y_reg[CW-1], start_y_reg});
            dz_reg     <= $signed({end_z_reg[CW-1], end_z_reg}) - $signed({start_z_reg[CW-1], start_z_reg});
            t_reg      <= '0;
            tr_acc_reg <= '0;
            idx_reg    <= '0;
        end

        // M for z: (E-S)<<16 + 2*u*h
        if (state_reg == blra_pkg::ST_PT_U_WAIT && !mul_z_busy) begin
            mz_reg <= $signed({{(AW - DW - 16){dz_reg[DW-1]}}, dz_reg, 16'b0})
                    + $signed({mul_z_prod[AW-2:0], 1'b0});
        end

        // Rounded offsets
        if (state_reg == blra_pkg::ST_PT_RND) begin
            rnd_x_reg <= rs_x[PW-1:32];
            rnd_y_reg <= rs_y[PW-1:32];
            rnd_z_reg <= rs_z[PW-1:32];
        end

        // Output register and point advance
        if (out_load) begin
            out_x_reg      <= sat_add(start_x_reg, rnd_x_reg);
            out_y_reg      <= sat_add(start_y_reg, rnd_y_reg);
            out_z_reg      <= sat_add(start_z_reg, rnd_z_reg);
            out_idx_reg    <= idx_reg;
            out_last_reg   <= idx_done;
            out_hiding_reg <= hiding_reg;
            idx_reg        <= idx_reg + 1'b1;
            t_reg          <= t_reg + div_quot + blra_pkg::PROG_W'(tr_carry);
            tr_acc_reg     <= tr_carry
                            ? blra_pkg::NP_W'(tr_sum - (blra_pkg::NP_W + 1)'(blra_pkg::NUM_POINTS))
                            : blra_pkg::NP_W'(tr_sum);
        end
    end

    // ---------------------------------------------------------------
    // Result stream
    // ---------------------------------------------------------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(blra_pkg::M_TDATA_W - blra_pkg::M_USED_W){1'b0}},
                       out_idx_reg, out_z_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_hiding_reg;

endmodule

`default_nettype wire

[hw/rtl/blra_checker.sv]
// Port-level checks for the bezier leg reach animator, bound to the top level.
// Depends on blra_pkg for the point count and output field offsets.
`default_nettype none

module blra_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [blra_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic                              m_tlast
);

    logic [blra_pkg::IDX_W-1:0] idx;
    assign idx = m_tdata[blra_pkg::M_IDX_LSB +: blra_pkg::IDX_W];

    // Stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // Nothing pending after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // last marks exactly the final point index
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (idx == blra_pkg::IDX_W'(blra_pkg::NUM_POINTS))))
        else $error("tlast does not match point index");

    // A non-final point still pending means the run goes on: no new item taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a point run");

endmodule

bind bezier_leg_reach_animator blra_checker u_blra_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[bench/tb_bezier_leg_reach_animator.sv]
// Self-checking testbench for bezier_leg_reach_animator: random and directed items on the s_ stream,
// curve points on the m_ stream checked against an in-bench predictor; registers set over APB.
// Depends on blra_pkg and the bezier_leg_reach_animator RTL.

module tb_bezier_leg_reach_animator;
    import blra_pkg::*;

    localparam int LIMIT_CYCLES  = 4_000_000;
    localparam int SETTLE_CYCLES = 120;      // a tick with no points still runs its progress step
    localparam int PHASES        = 8;
    localparam int MAX_PRINTS    = 40;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0] ADDR_HEIGHT = {REG_CTRL_HEIGHT, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPEED  = {REG_ANIM_SPEED, 2'b00};

    // Idling modes
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [DELTA_W-1:0]        delta;
        logic                      active;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic signed [COORD_W-1:0] tz;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sz;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] pz;
        logic [IDX_W-1:0]   idx;
        logic               last;
        logic               hiding;
    } point_t;

    // DUT connections
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_AW-1:0]     paddr    = '0;
    logic [APB_DW-1:0]     pwdata   = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // Bench state
    item_t  pending_items[$];
    point_t expected_points[$];
    item_t  held_item;
    int     sender_gap_pct = 0;
    int     recv_stall_pct = 0;
    int     cycle_count    = 0;
    int     mismatches     = 0;
    int     items_taken    = 0;
    int     points_checked = 0;
    int     settings_used  = 0;

    // Predictor copy of the limb state and registers
    logic   leg_on;
    logic   reach_run;
    logic   hide_run;
    longint prog;
    longint end_x, end_y, end_z;
    longint cfg_height;
    longint cfg_speed;

    bezier_leg_reach_animator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // One curve coordinate, rounded half up once, then saturated to 32 bits
    function automatic logic [COORD_W-1:0] curve_coord(longint s, longint e, longint t,
                                                       longint h);
        longint a, qa, ra, b, frac, v;
        a    = t * (e - s);
        qa   = a >>> 16;
        ra   = a - (qa <<< 16);
        b    = 2 * t * (ONE_Q16 - t) * h;
        frac = ra * ONE_Q16 + b + (longint'(1) <<< 31);
        v    = s + qa + (frac >>> 32);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[COORD_W-1:0];
    endfunction

    // Update the limb state for one accepted item and queue the points it causes
    function automatic void advance_limb(item_t it);
        longint step, p, t, sx, sy, sz;
        point_t pt;
        case (it.kind)
            KIND_SET_ACTIVE: begin
                leg_on = it.active;
                if (it.active) begin
                    prog      = 0;
                    reach_run = 1'b1;
                end else begin
                    prog     = ONE_Q16;
                    hide_run = 1'b1;
                end
            end
            KIND_SET_TARGET: begin
                end_x = longint'(signed'(it.tx));
                end_y = longint'(signed'(it.ty));
                end_z = longint'(signed'(it.tz));
            end
            KIND_TICK: begin
                // reach wins over hide; leaving 0..1 stops both ramps
                if (reach_run || hide_run) begin
                    step = (longint'(it.delta) * cfg_speed) >>> 8;
                    p    = reach_run ? prog + step : prog - step;
                    if (p > ONE_Q16 || p < 0) begin
                        reach_run = 1'b0;
                        hide_run  = 1'b0;
                    end
                    if (p > ONE_Q16)
                        p = ONE_Q16;
                    if (p < 0)
                        p = 0;
                    prog = p;
                end
                if (leg_on || hide_run) begin
                    sx = longint'(signed'(it.sx));
                    sy = longint'(signed'(it.sy));
                    sz = longint'(signed'(it.sz));
                    for (int i = 0; i <= NUM_POINTS; i++) begin
                        t         = (longint'(i) * prog) / NUM_POINTS;
                        pt.px     = curve_coord(sx, end_x, t, 0);
                        pt.py     = curve_coord(sy, end_y, t, 0);
                        pt.pz     = curve_coord(sz, end_z, t, cfg_height);
                        pt.idx    = IDX_W'(i);
                        pt.last   = (i == NUM_POINTS);
                        pt.hiding = hide_run;
                        expected_points.push_back(pt);
                    end
                end
            end
            default: ;  // unused kind, ignored
        endcase
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_item(item_t it);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[S_DELTA_LSB +: DELTA_W] = it.delta;
        d[S_ACTIVE_BIT]           = it.active;
        d[S_TX_LSB +: COORD_W]    = it.tx;
        d[S_TY_LSB +: COORD_W]    = it.ty;
        d[S_TZ_LSB +: COORD_W]    = it.tz;
        d[S_SX_LSB +: COORD_W]    = it.sx;
        d[S_SY_LSB +: COORD_W]    = it.sy;
        d[S_SZ_LSB +: COORD_W]    = it.sz;
        return d;
    endfunction

    // Input driver: holds an item until taken, then predicts its points
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_limb(held_item);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
                    held_item = pending_items.pop_front();
                    s_tdata  <= pack_item(held_item);
                    s_tuser  <= held_item.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure, compare against the oldest expected point
    always @(posedge aclk) begin
        point_t exp_pt;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    flag_mismatch($sformatf("unexpected point, index %0d",
                                            m_tdata[M_IDX_LSB +: IDX_W]));
                end else begin
                    exp_pt = expected_points.pop_front();
                    points_checked++;
                    if (m_tdata[M_PX_LSB +: COORD_W] !== exp_pt.px)
                        flag_mismatch($sformatf("point_x %h, want %h",
                                                m_tdata[M_PX_LSB +: COORD_W], exp_pt.px));
                    if (m_tdata[M_PY_LSB +: COORD_W] !== exp_pt.py)
                        flag_mismatch($sformatf("point_y %h, want %h",
                                                m_tdata[M_PY_LSB +: COORD_W], exp_pt.py));
                    if (m_tdata[M_PZ_LSB +: COORD_W] !== exp_pt.pz)
                        flag_mismatch($sformatf("point_z %h, want %h",
                                                m_tdata[M_PZ_LSB +: COORD_W], exp_pt.pz));
                    if (m_tdata[M_IDX_LSB +: IDX_W] !== exp_pt.idx)
                        flag_mismatch($sformatf("point_index %0d, want %0d",
                                                m_tdata[M_IDX_LSB +: IDX_W], exp_pt.idx));
                    if (m_tlast !== exp_pt.last)
                        flag_mismatch($sformatf("last %b, want %b", m_tlast, exp_pt.last));
                    if (m_tuser !== exp_pt.hiding)
                        flag_mismatch($sformatf("hiding %b, want %b", m_tuser, exp_pt.hiding));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_bezier_leg_reach_animator NOT OK");
            $finish;
        end
    end

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] want);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want)
            flag_mismatch($sformatf("register %0d reads %h, want %h", addr, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] height, input logic [15:0] speed);
        apb_write(ADDR_HEIGHT, height);
        apb_write(ADDR_SPEED, {16'h0, speed});
        cfg_height = longint'(signed'(height));
        cfg_speed  = longint'(speed);
        apb_read_check(ADDR_HEIGHT, height);
        apb_read_check(ADDR_SPEED, {16'h0, speed});
        settings_used++;
        @(negedge aclk);
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                sender_gap_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_gap_pct = 87;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_gap_pct = 0;
                recv_stall_pct = 87;
            end
            default: begin
                sender_gap_pct = 19;
                recv_stall_pct = 19;
            end
        endcase
    endtask

    // Wait until the sender is out of items and every expected point has come
    task automatic drain_all();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_points.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_delta();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2, 3:    return 16'($urandom_range(1, 20000));
            default: return 16'($urandom);
        endcase
    endfunction

    // Every field random; the caller overrides what the kind uses
    function automatic item_t base_item(input logic [KIND_W-1:0] kind);
        item_t it;
        it.kind   = kind;
        it.delta  = 16'($urandom);
        it.active = 1'($urandom);
        it.tx     = $urandom;
        it.ty     = $urandom;
        it.tz     = $urandom;
        it.sx     = $urandom;
        it.sy     = $urandom;
        it.sz     = $urandom;
        return it;
    endfunction

    task automatic push_target(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        item_t it;
        it    = base_item(KIND_SET_TARGET);
        it.tx = x;
        it.ty = y;
        it.tz = z;
        pending_items.push_back(it);
    endtask

    task automatic push_active(input logic act);
        item_t it;
        it        = base_item(KIND_SET_ACTIVE);
        it.active = act;
        pending_items.push_back(it);
    endtask

    task automatic push_tick(input logic [15:0] delta, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        item_t it;
        it       = base_item(KIND_TICK);
        it.delta = delta;
        it.sx    = x;
        it.sy    = y;
        it.sz    = z;
        pending_items.push_back(it);
    endtask

    // Mostly reach/hide sequences with random content, some loose items
    task automatic queue_random(input int count);
        int queued;
        int n;
        logic [KIND_W-1:0] k;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(99) < 80) begin
                push_target(rand_coord(), rand_coord(), rand_coord());
                push_active(1'b1);
                n = $urandom_range(1, 4);
                repeat (n) push_tick(rand_delta(), rand_coord(), rand_coord(), rand_coord());
                push_active(1'b0);
                queued += n + 3;
                n = $urandom_range(0, 4);
                repeat (n) push_tick(rand_delta(), rand_coord(), rand_coord(), rand_coord());
                queued += n;
            end else begin
                k = KIND_W'($urandom_range(3));
                pending_items.push_back(base_item(k));
                if (k != KIND_UNUSED)
                    queued++;
            end
        end
    endtask

    // Directed: reset state, extremes, ramp overlap and exact boundaries
    task automatic queue_directed();
        // idle limb after reset gives nothing; unused kind is ignored
        push_tick(16'h1234, 32'h0, 32'h0, 32'h0);
        pending_items.push_back(base_item(KIND_UNUSED));
        // full-range reach: progress 0, a quarter, then overshoot clamps to 1
        push_target(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_active(1'b1);
        push_tick(16'h0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_tick(16'h4000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_tick(16'hffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_tick(16'hffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        // hide, then reach while still hiding: both flags up, reach wins
        push_active(1'b0);
        push_tick(16'h0000, 32'h0, 32'h0, 32'h0);
        push_active(1'b1);
        push_tick(16'd30000, 32'h0, 32'h0, 32'h0);
        push_tick(16'hffff, 32'h0, 32'h0, 32'h0);
        // hide below zero: ramp stops and the inactive limb goes quiet
        push_target(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_active(1'b0);
        push_tick(16'd40000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_tick(16'd40000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_tick(16'd100, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        // progress landing exactly on 1 keeps the ramp running
        push_active(1'b1);
        push_tick(16'h8000, 32'h1, 32'hffff_ffff, 32'h0);
        push_tick(16'h8000, 32'h1, 32'hffff_ffff, 32'h0);
        push_tick(16'h0001, 32'h1, 32'hffff_ffff, 32'h0);
        push_tick(16'h0001, 32'h1, 32'hffff_ffff, 32'h0);
    endtask

    // Main sequence
    initial begin
        logic [31:0] height;
        logic [15:0] speed;
        leg_on     = 1'b0;
        reach_run  = 1'b0;
        hide_run   = 1'b0;
        prog       = 0;
        end_x      = 0;
        end_y      = 0;
        end_z      = 0;
        cfg_height = longint'(CTRL_HEIGHT_RST);
        cfg_speed  = longint'(ANIM_SPEED_RST);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values, then directed items at the defaults
        apb_read_check(ADDR_HEIGHT, CTRL_HEIGHT_RST);
        apb_read_check(ADDR_SPEED, {16'h0, ANIM_SPEED_RST});
        set_idle(IDLE_BOTH);
        queue_directed();
        drain_all();

        // random phases over register settings and idling modes
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    height = 32'h8000_0000;
                    speed  = 16'hffff;
                end
                1: begin
                    height = 32'h7fff_ffff;
                    speed  = 16'd1;
                end
                2: begin
                    height = 32'h0;
                    speed  = 16'd0;
                end
                3: begin
                    height = 32'hffff_ffff;
                    speed  = 16'd256;
                end
                default: begin
                    height = rand_coord();
                    speed  = 16'($urandom_range(64, 8192));
                end
            endcase
            set_idle(idle_mode_t'(ph % 4));
            set_config(height, speed);
            // the sender runs dry halfway and waits for every point
            queue_random(21);
            drain_all();
            queue_random(21);
            drain_all();
        end

        $display("run covered %0d items and %0d curve points over %0d register settings",
                 items_taken, points_checked, settings_used);
        if (mismatches == 0) begin
            $display("tb_bezier_leg_reach_animator OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_bezier_leg_reach_animator NOT OK");
        end
        $finish;
    end

endmodule
